// File: design/ctcg_pkg.sv
// shared types, widths and codes of the ctc greedy decoder
package ctcg_pkg;

  localparam int SCORE_W = 16;
  localparam int CC_W = 8;
  localparam int KIND_W = 2;
  localparam int IDX_W = 7;
  localparam int SUM_W = 26;
  localparam int CNT_W = 11;
  localparam int ACC_LIMIT = 1024;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int MAX_CLASSES_DEF = 128;
  localparam logic [CC_W-1:0] CLASS_COUNT_RST = 8'd128;

  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPACE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic take;
    logic load_char;
    logic div_load;
    logic div_step;
    logic load_sum;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
  } status_t;

endpackage

// File: design/ctcg_if.sv
// stream and configuration channel interfaces
interface ctcg_sample_if;
  logic valid;
  logic ready;
  logic [ctcg_pkg::SCORE_W-1:0] score;
  logic line_end;
  modport source (output valid, output score, output line_end, input ready);
  modport sink (input valid, input score, input line_end, output ready);
endinterface

interface ctcg_result_if;
  logic valid;
  logic ready;
  logic [ctcg_pkg::KIND_W-1:0] kind;
  logic [ctcg_pkg::IDX_W-1:0] class_index;
  logic [ctcg_pkg::SCORE_W-1:0] confidence;
  logic last;
  modport source (output valid, output kind, output class_index, output confidence,
                  output last, input ready);
  modport sink (input valid, input kind, input class_index, input confidence,
                input last, output ready);
endinterface

interface ctcg_cfg_if;
  logic valid;
  logic ready;
  logic [ctcg_pkg::CC_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/ctcg_ctrl.sv
// controller state machine of the ctc greedy decoder
module ctcg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_line_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ctcg_pkg::status_t status,
  output ctcg_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_DLOAD = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;
  localparam logic [1:0] ST_SUM = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;
  logic       accept;

  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == ST_RUN) && slot_free;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (status.emit) begin
            cmd.load_char = 1'b1;
            out_valid_next = 1'b1;
          end
          if (in_line_end) begin
            state_next = ST_DLOAD;
          end
        end
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_SUM;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          cmd.load_sum = 1'b1;
          cmd.clear = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_dload_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DLOAD) |=> (state == ST_DIV))
    else $error("divider load not followed by division");

  a_sum_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_sum |=> (out_valid && state == ST_RUN))
    else $error("summary load did not present a result");

  a_line_end_stops_input: assert property (@(posedge clk) disable iff (rst)
    (accept && in_line_end) |=> !in_ready)
    else $error("input taken while summary pending");

endmodule

// File: design/ctcg_datapath.sv
// line state, step judging, divider and result register
module ctcg_datapath #(
  parameter int MAX_CLASSES = ctcg_pkg::MAX_CLASSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctcg_pkg::cmd_t                cmd,
  output ctcg_pkg::status_t             status,
  input  logic                          cfg_we,
  input  logic [ctcg_pkg::CC_W-1:0]     cfg_data,
  input  logic [ctcg_pkg::SCORE_W-1:0]  in_score,
  input  logic                          in_line_end,
  output logic [ctcg_pkg::KIND_W-1:0]   out_kind,
  output logic [ctcg_pkg::IDX_W-1:0]    out_class_index,
  output logic [ctcg_pkg::SCORE_W-1:0]  out_confidence,
  output logic                          out_last
);

  localparam int POS_W = $clog2(MAX_CLASSES);
  localparam int FULL_W = $clog2(MAX_CLASSES + 1);
  localparam int CMP_W = (FULL_W > ctcg_pkg::CC_W) ? FULL_W : ctcg_pkg::CC_W;
  localparam int SUM_W = ctcg_pkg::SUM_W;
  localparam int CNT_W = ctcg_pkg::CNT_W;

  logic [ctcg_pkg::CC_W-1:0]    class_count;
  logic [POS_W-1:0]             position;
  logic [ctcg_pkg::SCORE_W-1:0] top_score;
  logic [POS_W-1:0]             top_class;
  logic [POS_W-1:0]             previous_class;
  logic                         previous_valid;
  logic [SUM_W-1:0]             score_sum;
  logic [CNT_W-1:0]             emit_count;
  logic [SUM_W-1:0]             quot;
  logic [CNT_W-1:0]             rem;
  logic [ctcg_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [CMP_W-1:0]             cc_ext;
  logic [CMP_W-1:0]             eff_count;
  logic [CMP_W-1:0]             pos_inc;
  logic [ctcg_pkg::SCORE_W-1:0] cand_score;
  logic [POS_W-1:0]             cand_class;
  logic                         step_close;
  logic                         emit;
  logic                         is_space;
  logic                         acc_open;
  logic [CNT_W:0]               rem_shift;
  logic                         rem_ge;

  assign cc_ext = CMP_W'(class_count);

  always_comb begin
    if (cc_ext < CMP_W'(3)) begin
      eff_count = CMP_W'(3);
    end else if (cc_ext > CMP_W'(MAX_CLASSES)) begin
      eff_count = CMP_W'(MAX_CLASSES);
    end else begin
      eff_count = cc_ext;
    end
  end

  assign pos_inc = CMP_W'(position) + CMP_W'(1);

  always_comb begin
    if (position == '0 || in_score > top_score) begin
      cand_score = in_score;
      cand_class = position;
    end else begin
      cand_score = top_score;
      cand_class = top_class;
    end
  end

  assign step_close = (pos_inc >= eff_count) || in_line_end;
  assign emit = step_close && (cand_class != '0)
                && !(previous_valid && cand_class == previous_class);
  assign is_space = CMP_W'(cand_class) == (eff_count - CMP_W'(1));
  assign acc_open = emit_count < CNT_W'(ctcg_pkg::ACC_LIMIT);

  assign rem_shift = {rem, quot[SUM_W-1]};
  assign rem_ge = rem_shift >= {1'b0, emit_count};

  assign status.emit = emit;
  assign status.div_done = div_cnt == ctcg_pkg::DIV_CNT_W'(ctcg_pkg::DIV_STEPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= ctcg_pkg::CLASS_COUNT_RST;
    end else if (cfg_we) begin
      class_count <= cfg_data;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      position <= '0;
      top_score <= '0;
      top_class <= '0;
      previous_class <= '0;
      previous_valid <= 1'b0;
      score_sum <= '0;
      emit_count <= '0;
    end else if (cmd.take) begin
      if (step_close) begin
        previous_class <= cand_class;
        previous_valid <= 1'b1;
        position <= '0;
        top_score <= '0;
        top_class <= '0;
        if (emit && acc_open) begin
          score_sum <= score_sum + SUM_W'(cand_score);
          emit_count <= emit_count + CNT_W'(1);
        end
      end else begin
        position <= pos_inc[POS_W-1:0];
        top_score <= cand_score;
        top_class <= cand_class;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + ctcg_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quot <= score_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= CNT_W'(rem_shift - {1'b0, emit_count});
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CNT_W-1:0];
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      out_kind <= is_space ? ctcg_pkg::KIND_SPACE : ctcg_pkg::KIND_CHAR;
      out_class_index <= ctcg_pkg::IDX_W'(cand_class);
      out_confidence <= cand_score;
      out_last <= !in_line_end;
    end else if (cmd.load_sum) begin
      out_kind <= ctcg_pkg::KIND_SUMMARY;
      out_class_index <= '0;
      out_confidence <= (emit_count == '0) ? '0 : quot[ctcg_pkg::SCORE_W-1:0];
      out_last <= 1'b1;
    end
  end

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    emit_count <= CNT_W'(ctcg_pkg::ACC_LIMIT))
    else $error("emission count beyond accumulator limit");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !status.div_done)
    else $error("divider stepped past its last bit");

endmodule

// File: design/ctc_greedy_decoder_top.sv
// top level of the ctc greedy decoder
// Class scores stream in one per cycle, class by class within a step; while a line is
// running the block takes one score every cycle as long as the result register is free or
// being drained. A score that ends a step may yield a character or space result, presented
// on the cycle after its transfer. The score flagged as line end is followed by a summary
// result with the mean confidence: the bit-serial restoring divider is loaded, steps through
// all quotient bits until it is seen done, and then the summary is loaded, so input pauses
// after each line end until the summary is loaded, longer while an earlier result still waits.
// class_count may be written whenever the block is idle; it is clamped to 3 .. MAX_CLASSES.
module ctc_greedy_decoder_top #(
  parameter int MAX_CLASSES = ctcg_pkg::MAX_CLASSES_DEF
) (
  input  logic clk,
  input  logic rst,
  ctcg_sample_if.sink   samples,
  ctcg_result_if.source results,
  ctcg_cfg_if.sink      cfg
);

  ctcg_pkg::cmd_t    cmd;
  ctcg_pkg::status_t status;

  assign cfg.ready = 1'b1;

  ctcg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (samples.valid),
    .in_line_end (samples.line_end),
    .in_ready    (samples.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .status      (status),
    .cmd         (cmd)
  );

  ctcg_datapath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_data        (cfg.data),
    .in_score        (samples.score),
    .in_line_end     (samples.line_end),
    .out_kind        (results.kind),
    .out_class_index (results.class_index),
    .out_confidence  (results.confidence),
    .out_last        (results.last)
  );

endmodule
